/* rtl/core/assert_macros.svh */
// Assertion macros shared by the modular exponentiation RTL.
// Included by any file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define MX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the following cycle.
`define MX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/modexp_pkg.sv */
// Package for the modular exponentiation block: widths, register indexes and
// the sequencer state type. No dependencies.
package modexp_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int MOD_WIDTH_DEF   = 32;
    localparam int EXP_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PUBLIC_EXP  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRIVATE_EXP = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_FINISH
    } t_state;

endpackage

/* rtl/core/modular_exponentiation_top.sv */
// Modular exponentiation (RSA encrypt and decrypt) with a bit-serial modular multiplier.
// Depends on modexp_pkg and assert_macros.svh.
//
// Usage: an item on the input channel (i_in_valid / o_in_ready) carries an operation
// bit and a base value; the operation selects the public or the private exponent.
// One result, base to that exponent modulo the modulus, leaves on the output channel
// (o_out_valid / i_out_ready). The modulus and exponents are set through the write
// port (i_cfg_we, i_cfg_index, i_cfg_data); the user must write them only while the
// block is idle, which the block does not enforce. One item is processed at a time.
// After the transfer and a setup state the base is reduced modulo the modulus, then each
// of the 32 exponent bits costs a modular squaring, plus a modular multiplication when
// the bit is set. The result then waits in the finish state until the output register
// is free, and the next item is taken once the sequencer is back in idle. With a zero
// exponent or a modulus below two the setup state goes straight to the finish state.
// The rate is set by the interleaved multiplier, which consumes one multiplier bit per
// cycle.
// Reset returns the sequencer to idle, drops the output valid and restores the
// modulus to two and both exponents to zero. When the receiver stalls, the result
// holds in the output register; a new item is still accepted and computed, and it
// waits at its final step until the output register is free.
`include "assert_macros.svh"

module modular_exponentiation_top #(
    parameter int MOD_WIDTH = modexp_pkg::MOD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [modexp_pkg::DATA_WIDTH-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_operation,
    input  logic [modexp_pkg::DATA_WIDTH-1:0]      i_base_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [modexp_pkg::DATA_WIDTH-1:0]      o_result_value
);
    import modexp_pkg::*;

    localparam int CNT_W  = $clog2(MOD_WIDTH);
    localparam int ECNT_W = $clog2(EXP_WIDTH);

    t_state                 r_state, n_state;
    logic [DATA_WIDTH-1:0]  r_modulus, r_pub_exp, r_priv_exp;
    logic [EXP_WIDTH-1:0]   r_e, n_e;
    logic [ECNT_W-1:0]      r_ecnt, n_ecnt;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [MOD_WIDTH-1:0]   r_base, n_base;
    logic [MOD_WIDTH-1:0]   r_acc, n_acc;
    logic [MOD_WIDTH-1:0]   r_a, n_a;
    logic [MOD_WIDTH-1:0]   r_b, n_b;
    logic [MOD_WIDTH-1:0]   r_p, n_p;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_WIDTH-1:0]  r_out, n_out;

    logic [MOD_WIDTH-1:0]   mod_w;
    logic                   mod_small;
    logic                   in_xfer, out_free, step_last, exp_last;
    logic [MOD_WIDTH+1:0]   sum, sub1, sub2, mod_ext, mod_dbl;
    logic [MOD_WIDTH-1:0]   p_step;

    assign mod_w     = r_modulus[MOD_WIDTH-1:0];
    assign mod_small = ~|mod_w[MOD_WIDTH-1:1];
    assign in_xfer   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign step_last = (r_cnt == '0);
    assign exp_last  = (r_ecnt == '0);

    // One step of the interleaved multiplier: p = (2p + a_bit * b) mod m, with p, b < m.
    assign mod_ext = {2'b00, mod_w};
    assign mod_dbl = {1'b0, mod_w, 1'b0};
    assign sum     = {1'b0, r_p, 1'b0} + {2'b00, (r_a[MOD_WIDTH-1] ? r_b : '0)};
    assign sub1    = sum - mod_ext;
    assign sub2    = sum - mod_dbl;

    always_comb begin
        if (sum >= mod_dbl) begin
            p_step = sub2[MOD_WIDTH-1:0];
        end else if (sum >= mod_ext) begin
            p_step = sub1[MOD_WIDTH-1:0];
        end else begin
            p_step = sum[MOD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= DATA_WIDTH'(2);
            r_pub_exp  <= '0;
            r_priv_exp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODULUS:     r_modulus  <= i_cfg_data;
                CFG_PUBLIC_EXP:  r_pub_exp  <= i_cfg_data;
                CFG_PRIVATE_EXP: r_priv_exp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if ((r_e == '0) || mod_small) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (step_last) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE, S_MULT: begin
                if (step_last) begin
                    if ((r_state == S_SQUARE) && r_e[EXP_WIDTH-1]) begin
                        n_state = S_MULT;
                    end else if (exp_last) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_SQUARE;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        n_e         = r_e;
        n_ecnt      = r_ecnt;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_acc       = r_acc;
        n_a         = r_a;
        n_b         = r_b;
        n_p         = r_p;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_e    = (i_operation == OP_DECRYPT) ? r_priv_exp : r_pub_exp;
                    n_base = i_base_value[MOD_WIDTH-1:0];
                end
            end
            S_SETUP: begin
                n_a    = r_base;
                n_b    = MOD_WIDTH'(1);
                n_p    = '0;
                n_cnt  = CNT_W'(MOD_WIDTH - 1);
                n_ecnt = ECNT_W'(EXP_WIDTH - 1);
                if (r_e == '0) begin
                    n_acc = MOD_WIDTH'(1);
                end else begin
                    n_acc = '0;
                end
            end
            S_REDUCE: begin
                n_p   = p_step;
                n_a   = {r_a[MOD_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (step_last) begin
                    n_base = p_step;
                    n_a    = MOD_WIDTH'(1);
                    n_b    = MOD_WIDTH'(1);
                    n_p    = '0;
                    n_cnt  = CNT_W'(MOD_WIDTH - 1);
                end
            end
            S_SQUARE, S_MULT: begin
                n_p   = p_step;
                n_a   = {r_a[MOD_WIDTH-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
                if (step_last) begin
                    n_acc = p_step;
                    n_a   = p_step;
                    n_p   = '0;
                    n_cnt = CNT_W'(MOD_WIDTH - 1);
                    if ((r_state == S_SQUARE) && r_e[EXP_WIDTH-1]) begin
                        n_b = r_base;
                    end else begin
                        n_b    = p_step;
                        n_e    = {r_e[EXP_WIDTH-2:0], 1'b0};
                        n_ecnt = r_ecnt - 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out       = DATA_WIDTH'(r_acc);
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_ecnt <= n_ecnt;
        r_cnt  <= n_cnt;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_b    <= n_b;
        r_p    <= n_p;
        r_out  <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out;

    `MX_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_in_ready)
    `MX_ASSERT_IMP(a_partial_below_mod, i_clk, i_rst_n,
        (r_state == S_REDUCE) || (r_state == S_SQUARE) || (r_state == S_MULT), r_p < mod_w)
    `MX_ASSERT_NEXT(a_finish_loads_out, i_clk, i_rst_n,
        (r_state == S_FINISH) && out_free, o_out_valid && (r_state == S_IDLE))

endmodule
